// ===== hw/rtl/rmap_packet_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// RMAP packet encoder assertion macros
// Shared assertion wrappers for the encoder modules, clocked on clk_i and
// disabled while rst_ni is low. Define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef RMAP_PACKET_ENCODER_MACROS_SVH
`define RMAP_PACKET_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RMAP_ENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RMAP_ENC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define RMAP_ENC_ASSERT(label, prop, msg)
`define RMAP_ENC_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== hw/rtl/rmap_enc_pkg.sv =====
// ---------------------------------------------------------------------------
// RMAP encoder package
// Opcodes, register indexes, header constants, controller/datapath types and
// the RMAP CRC-8 step function.
// ---------------------------------------------------------------------------
package rmap_enc_pkg;

  // Input opcodes (carried in tuser).
  localparam logic [2:0] OP_READ_CMD    = 3'd0;
  localparam logic [2:0] OP_WRITE_CMD   = 3'd1;
  localparam logic [2:0] OP_READ_REPLY  = 3'd2;
  localparam logic [2:0] OP_WRITE_REPLY = 3'd3;
  localparam logic [2:0] OP_PAYLOAD     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET_PATH_BYTES = 3'd0;
  localparam logic [2:0] REG_TARGET_PATH_COUNT = 3'd1;
  localparam logic [2:0] REG_REPLY_ADDR_LOW    = 3'd2;
  localparam logic [2:0] REG_REPLY_ADDR_HIGH   = 3'd3;
  localparam logic [2:0] REG_REPLY_ADDR_COUNT  = 3'd4;
  localparam logic [2:0] REG_TARGET_LA         = 3'd5;
  localparam logic [2:0] REG_INITIATOR_LA      = 3'd6;
  localparam logic [2:0] REG_ACCESS_KEY        = 3'd7;

  localparam logic [3:0] MAX_PATH_BYTES       = 4'd8;
  localparam logic [3:0] MAX_REPLY_ADDR_BYTES = 4'd12;

  localparam logic [7:0] LA_RESET   = 8'hFE;
  localparam logic [7:0] PROTO_ID   = 8'h01;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] CRC_POLY_R = 8'hE0;

  // Segment lengths in bytes.
  localparam logic [3:0] LEAD_LEN       = 4'd4;
  localparam logic [3:0] CMD_TAIL_LEN   = 4'd11;
  localparam logic [3:0] RREPLY_TAIL_LEN = 4'd7;
  localparam logic [3:0] WREPLY_TAIL_LEN = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PATH,
    ST_LEAD,
    ST_PAD,
    ST_RADDR,
    ST_TAIL,
    ST_HCRC,
    ST_DCRC
  } state_e;

  typedef enum logic [2:0] {
    SEL_PATH,
    SEL_LEAD,
    SEL_PAD,
    SEL_RADDR,
    SEL_TAIL,
    SEL_HCRC,
    SEL_DCRC
  } sel_e;

  typedef struct packed {
    logic load_hdr;
    logic take_pay;
    logic emit;
    sel_e sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic seg_end;
    logic is_cmd;
    logic path_empty;
    logic pad_empty;
    logic ra_empty;
    logic pl_none;
    logic pl_last;
    logic dcrc_follow;
  } dp_status_t;

  // RMAP CRC-8, polynomial x^8+x^2+x+1, bits taken LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rmap_enc_ctrl.sv =====
// ---------------------------------------------------------------------------
// RMAP encoder controller
// Sequences the header segments of a packet and the trailing data CRC.
// ---------------------------------------------------------------------------
`include "rmap_packet_encoder_macros.svh"

module rmap_enc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [2:0]               opcode_i,
  output logic                     in_ready_o,
  input  rmap_enc_pkg::dp_status_t status_i,
  output rmap_enc_pkg::ctrl_cmd_t  cmd_o
);
  import rmap_enc_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  logic   emit;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q != ST_IDLE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_PAYLOAD) begin
            if (!status_i.pl_none && status_i.pl_last) begin
              state_d = ST_DCRC;
            end
          end else if (!opcode_i[2]) begin
            if (!opcode_i[1]) begin
              state_d = status_i.path_empty ? ST_LEAD : ST_PATH;
            end else begin
              state_d = status_i.ra_empty ? ST_LEAD : ST_RADDR;
            end
          end
        end
      end
      ST_PATH: begin
        if (emit && status_i.seg_end) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (emit && status_i.seg_end) begin
          if (!status_i.is_cmd) begin
            state_d = ST_TAIL;
          end else if (!status_i.pad_empty) begin
            state_d = ST_PAD;
          end else if (!status_i.ra_empty) begin
            state_d = ST_RADDR;
          end else begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_PAD: begin
        if (emit && status_i.seg_end) begin
          state_d = status_i.ra_empty ? ST_TAIL : ST_RADDR;
        end
      end
      ST_RADDR: begin
        if (emit && status_i.seg_end) begin
          state_d = status_i.is_cmd ? ST_TAIL : ST_LEAD;
        end
      end
      ST_TAIL: begin
        if (emit && status_i.seg_end) begin
          state_d = ST_HCRC;
        end
      end
      ST_HCRC: begin
        if (emit) begin
          state_d = status_i.dcrc_follow ? ST_DCRC : ST_IDLE;
        end
      end
      ST_DCRC: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_hdr = accept && !opcode_i[2];
    cmd_o.take_pay = accept && (opcode_i == OP_PAYLOAD);
    cmd_o.emit     = emit;
    case (state_q)
      ST_PATH:  cmd_o.sel = SEL_PATH;
      ST_LEAD:  cmd_o.sel = SEL_LEAD;
      ST_PAD:   cmd_o.sel = SEL_PAD;
      ST_RADDR: cmd_o.sel = SEL_RADDR;
      ST_TAIL:  cmd_o.sel = SEL_TAIL;
      ST_DCRC:  cmd_o.sel = SEL_DCRC;
      default:  cmd_o.sel = SEL_HCRC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The data CRC only ever follows the header CRC or the final payload word.
  `RMAP_ENC_ASSERT(a_dcrc_entry, (state_q == ST_DCRC && $past(state_q) != ST_DCRC) |-> ($past(state_q) == ST_HCRC || $past(state_q) == ST_IDLE), "data CRC entered from a header segment")
  // Path and padding segments belong to command packets only.
  `RMAP_ENC_ASSERT(a_cmd_only_segs, (state_q == ST_PATH || state_q == ST_PAD) |-> status_i.is_cmd, "path or padding emitted in a reply")

endmodule

// ===== hw/rtl/rmap_enc_dp.sv =====
// ---------------------------------------------------------------------------
// RMAP encoder datapath
// Configuration registers, latched header fields, CRC and payload state, the
// byte selector and the output word register.
// ---------------------------------------------------------------------------
`include "rmap_packet_encoder_macros.svh"

module rmap_enc_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration access
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [63:0]              cfg_wdata_i,
  output logic [63:0]              cfg_rdata_o,
  // Input item fields
  input  logic [2:0]               opcode_i,
  input  logic                     increment_i,
  input  logic                     verify_i,
  input  logic                     reply_wanted_i,
  input  logic [7:0]               reply_status_i,
  input  logic [15:0]              transaction_id_i,
  input  logic [7:0]               extended_address_i,
  input  logic [31:0]              memory_address_i,
  input  logic [23:0]              data_length_i,
  input  logic [7:0]               data_byte_i,
  // Controller link
  input  rmap_enc_pkg::ctrl_cmd_t  cmd_i,
  output rmap_enc_pkg::dp_status_t status_o,
  // Output word
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [7:0]               out_byte_o,
  output logic                     end_of_packet_o,
  output logic                     last_o,
  output logic                     error_o
);
  import rmap_enc_pkg::*;

  // Configuration
  logic [63:0] tpath_q;
  logic [3:0]  tpath_cnt_q;
  logic [63:0] raddr_lo_q;
  logic [31:0] raddr_hi_q;
  logic [3:0]  raddr_cnt_q;
  logic [7:0]  tla_q;
  logic [7:0]  ila_q;
  logic [7:0]  key_q;

  // Latched header request
  logic [2:0]  op_q;
  logic        inc_q;
  logic        ver_q;
  logic        rep_q;
  logic [7:0]  status_q;
  logic [15:0] tid_q;
  logic [7:0]  ext_q;
  logic [31:0] addr_q;
  logic [23:0] len_q;

  logic [23:0] pl_rem_q, pl_rem_d;
  logic [7:0]  dcrc_q, dcrc_d;
  logic [7:0]  hcrc_q, hcrc_d;
  logic [3:0]  cnt_q, cnt_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_eop_q, out_eop_d;
  logic        out_last_q, out_last_d;
  logic        out_err_q, out_err_d;

  logic [3:0]       pc, ra, padded, pad_len, tail_len, seg_len;
  logic             is_cmd, has_payload, dcrc_follow, crc_cover, load_has_payload;
  logic [7:0]       instr, lead_byte, tail_byte, hdr_byte;
  logic [7:0][7:0]  path_arr;
  logic [11:0][7:0] ra_arr;

  assign pc      = (tpath_cnt_q > MAX_PATH_BYTES) ? MAX_PATH_BYTES : tpath_cnt_q;
  assign ra      = (raddr_cnt_q > MAX_REPLY_ADDR_BYTES) ? MAX_REPLY_ADDR_BYTES : raddr_cnt_q;
  // Reply address is padded to the next multiple of four bytes.
  assign padded  = (ra == 4'd0) ? 4'd0 : (((ra - 4'd1) & 4'hC) + 4'd4);
  assign pad_len = padded - ra;

  assign path_arr = tpath_q;
  assign ra_arr   = {raddr_hi_q, raddr_lo_q};

  assign is_cmd           = !op_q[1];
  assign has_payload      = (op_q == OP_WRITE_CMD) || (op_q == OP_READ_REPLY);
  assign dcrc_follow      = has_payload && (len_q == 24'd0);
  assign load_has_payload = (opcode_i == OP_WRITE_CMD) || (opcode_i == OP_READ_REPLY);

  always_comb begin
    case (op_q)
      OP_READ_CMD:    instr = {2'b01, 1'b0, 1'b0, 1'b1, inc_q, padded[3:2]};
      OP_WRITE_CMD:   instr = {2'b01, 1'b1, ver_q, rep_q, inc_q, padded[3:2]};
      OP_READ_REPLY:  instr = {2'b00, 1'b0, 1'b0, 1'b1, inc_q, 2'b00};
      default:        instr = {2'b00, 1'b1, ver_q, 1'b1, inc_q, 2'b00};
    endcase
  end

  always_comb begin
    case (cnt_q)
      4'd0:    lead_byte = is_cmd ? tla_q : ila_q;
      4'd1:    lead_byte = PROTO_ID;
      4'd2:    lead_byte = instr;
      default: lead_byte = is_cmd ? key_q : status_q;
    endcase
  end

  always_comb begin
    if (is_cmd) begin
      case (cnt_q)
        4'd0:    tail_byte = ila_q;
        4'd1:    tail_byte = tid_q[15:8];
        4'd2:    tail_byte = tid_q[7:0];
        4'd3:    tail_byte = ext_q;
        4'd4:    tail_byte = addr_q[31:24];
        4'd5:    tail_byte = addr_q[23:16];
        4'd6:    tail_byte = addr_q[15:8];
        4'd7:    tail_byte = addr_q[7:0];
        4'd8:    tail_byte = len_q[23:16];
        4'd9:    tail_byte = len_q[15:8];
        default: tail_byte = len_q[7:0];
      endcase
    end else begin
      case (cnt_q)
        4'd0:    tail_byte = tla_q;
        4'd1:    tail_byte = tid_q[15:8];
        4'd2:    tail_byte = tid_q[7:0];
        4'd3:    tail_byte = BYTE_ZERO;
        4'd4:    tail_byte = len_q[23:16];
        4'd5:    tail_byte = len_q[15:8];
        default: tail_byte = len_q[7:0];
      endcase
    end
  end

  always_comb begin
    if (is_cmd) begin
      tail_len = CMD_TAIL_LEN;
    end else if (op_q == OP_READ_REPLY) begin
      tail_len = RREPLY_TAIL_LEN;
    end else begin
      tail_len = WREPLY_TAIL_LEN;
    end
  end

  always_comb begin
    crc_cover = 1'b0;
    case (cmd_i.sel)
      SEL_PATH: begin
        hdr_byte = path_arr[cnt_q[2:0]];
        seg_len  = pc;
      end
      SEL_LEAD: begin
        hdr_byte  = lead_byte;
        seg_len   = LEAD_LEN;
        crc_cover = 1'b1;
      end
      SEL_PAD: begin
        hdr_byte  = BYTE_ZERO;
        seg_len   = pad_len;
        crc_cover = 1'b1;
      end
      SEL_RADDR: begin
        hdr_byte  = ra_arr[cnt_q];
        seg_len   = ra;
        // In a reply the reply address acts as the path and is not covered.
        crc_cover = is_cmd;
      end
      SEL_TAIL: begin
        hdr_byte  = tail_byte;
        seg_len   = tail_len;
        crc_cover = 1'b1;
      end
      SEL_DCRC: begin
        hdr_byte = dcrc_q;
        seg_len  = 4'd1;
      end
      default: begin
        hdr_byte = hcrc_q;
        seg_len  = 4'd1;
      end
    endcase
  end

  always_comb begin
    status_o.out_free    = !out_valid_q || out_ready_i;
    status_o.seg_end     = (cnt_q == seg_len - 4'd1);
    status_o.is_cmd      = is_cmd;
    status_o.path_empty  = (pc == 4'd0);
    status_o.pad_empty   = (pad_len == 4'd0);
    status_o.ra_empty    = (ra == 4'd0);
    status_o.pl_none     = (pl_rem_q == 24'd0);
    status_o.pl_last     = (pl_rem_q == 24'd1);
    status_o.dcrc_follow = dcrc_follow;
  end

  // Sequence state and CRCs
  always_comb begin
    pl_rem_d = pl_rem_q;
    dcrc_d   = dcrc_q;
    hcrc_d   = hcrc_q;
    cnt_d    = cnt_q;
    if (cmd_i.load_hdr) begin
      pl_rem_d = load_has_payload ? data_length_i : 24'd0;
      dcrc_d   = 8'd0;
      hcrc_d   = 8'd0;
      cnt_d    = 4'd0;
    end else if (cmd_i.take_pay) begin
      if (pl_rem_q != 24'd0) begin
        pl_rem_d = pl_rem_q - 24'd1;
        dcrc_d   = crc8_step(dcrc_q, data_byte_i);
      end
    end else if (cmd_i.emit) begin
      cnt_d = status_o.seg_end ? 4'd0 : cnt_q + 4'd1;
      if (crc_cover) begin
        hcrc_d = crc8_step(hcrc_q, hdr_byte);
      end
    end
  end

  // Output word register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_eop_d   = out_eop_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (cmd_i.take_pay) begin
      out_valid_d = 1'b1;
      out_eop_d   = 1'b0;
      if (status_o.pl_none) begin
        out_byte_d = BYTE_ZERO;
        out_last_d = 1'b1;
        out_err_d  = 1'b1;
      end else begin
        out_byte_d = data_byte_i;
        out_last_d = !status_o.pl_last;
        out_err_d  = 1'b0;
      end
    end else if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = hdr_byte;
      out_eop_d   = (cmd_i.sel == SEL_DCRC) || ((cmd_i.sel == SEL_HCRC) && !has_payload);
      out_last_d  = (cmd_i.sel == SEL_DCRC) || ((cmd_i.sel == SEL_HCRC) && !dcrc_follow);
      out_err_d   = 1'b0;
    end
  end

  always_comb begin
    case (cfg_idx_i)
      REG_TARGET_PATH_BYTES: cfg_rdata_o = tpath_q;
      REG_TARGET_PATH_COUNT: cfg_rdata_o = {60'd0, tpath_cnt_q};
      REG_REPLY_ADDR_LOW:    cfg_rdata_o = raddr_lo_q;
      REG_REPLY_ADDR_HIGH:   cfg_rdata_o = {32'd0, raddr_hi_q};
      REG_REPLY_ADDR_COUNT:  cfg_rdata_o = {60'd0, raddr_cnt_q};
      REG_TARGET_LA:         cfg_rdata_o = {56'd0, tla_q};
      REG_INITIATOR_LA:      cfg_rdata_o = {56'd0, ila_q};
      default:               cfg_rdata_o = {56'd0, key_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpath_q     <= 64'd0;
      tpath_cnt_q <= 4'd0;
      raddr_lo_q  <= 64'd0;
      raddr_hi_q  <= 32'd0;
      raddr_cnt_q <= 4'd0;
      tla_q       <= LA_RESET;
      ila_q       <= LA_RESET;
      key_q       <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_PATH_BYTES: tpath_q     <= cfg_wdata_i;
        REG_TARGET_PATH_COUNT: tpath_cnt_q <= cfg_wdata_i[3:0];
        REG_REPLY_ADDR_LOW:    raddr_lo_q  <= cfg_wdata_i;
        REG_REPLY_ADDR_HIGH:   raddr_hi_q  <= cfg_wdata_i[31:0];
        REG_REPLY_ADDR_COUNT:  raddr_cnt_q <= cfg_wdata_i[3:0];
        REG_TARGET_LA:         tla_q       <= cfg_wdata_i[7:0];
        REG_INITIATOR_LA:      ila_q       <= cfg_wdata_i[7:0];
        default:               key_q       <= cfg_wdata_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_rem_q    <= 24'd0;
      dcrc_q      <= 8'd0;
      hcrc_q      <= 8'd0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      pl_rem_q    <= pl_rem_d;
      dcrc_q      <= dcrc_d;
      hcrc_q      <= hcrc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_eop_q  <= out_eop_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
    if (cmd_i.load_hdr) begin
      op_q     <= opcode_i;
      inc_q    <= increment_i;
      ver_q    <= verify_i;
      rep_q    <= reply_wanted_i;
      status_q <= reply_status_i;
      tid_q    <= transaction_id_i;
      ext_q    <= extended_address_i;
      addr_q   <= memory_address_i;
      len_q    <= data_length_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign end_of_packet_o = out_eop_q;
  assign last_o          = out_last_q;
  assign error_o         = out_err_q;

  // A held word that the sink has not taken is never overwritten.
  `RMAP_ENC_ASSERT_NEVER(a_no_overrun, out_valid_q && !out_ready_i && (cmd_i.emit || cmd_i.take_pay), "output word overwritten while stalled")
  // The data CRC goes out only once no payload is outstanding.
  `RMAP_ENC_ASSERT(a_dcrc_done, (cmd_i.emit && cmd_i.sel == SEL_DCRC) |-> (pl_rem_q == 24'd0), "data CRC sent with payload pending")

endmodule

// ===== hw/rtl/rmap_packet_encoder.sv =====
// ---------------------------------------------------------------------------
// RMAP packet encoder
// Byte-serial encoder for RMAP command and reply packets with header and
// data CRC-8 generation, built as a controller plus datapath.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          request word (tuser opcode, tdata fields)
// m_axis    out        tvalid/tready          packet byte, tlast end of packet
// apb       in         psel/penable/pready    configuration registers at 8*index
//
// A payload word yields one byte; the final expected payload word is
// followed by the data CRC byte.
// A header word is accepted and then emits its bytes one at a time while the
// output is free (up to 37 bytes), as the controller walks the header segments.
// Output stalls hold the controller; a new word is taken only when the output
// register is empty or its byte leaves at the same clock edge.
// Reset is asynchronous and active low; it clears the state machine, the
// payload count and CRCs and restores the register reset values.
//
// The encoder never emits more than one byte per cycle. Path bytes, and the
// reply address when it acts as the path of a reply, stay out of the header
// CRC. A payload word with no payload outstanding yields a single error word
// and leaves all state alone; opcodes above the payload code are consumed
// silently. A new header abandons any unfinished payload.
// ---------------------------------------------------------------------------
module rmap_packet_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: increment[0], verify[1], reply_wanted[2], reply_status[10:3],
  //        transaction_id[26:11], extended_address[34:27], memory_address[66:35],
  //        data_length[90:67], data_byte[98:91], zero fill[103:99]
  input  logic [103:0] s_axis_tdata_i,
  // tuser: opcode[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  // Packet byte stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: out_byte[7:0]
  output logic [7:0]   m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // tuser: last[0], error[1]
  output logic [1:0]   m_axis_tuser_o,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import rmap_enc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  // Registers sit on 8-byte boundaries; the write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  rmap_enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmap_enc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (paddr[5:3]),
    .cfg_wdata_i        (pwdata),
    .cfg_rdata_o        (prdata),
    .opcode_i           (s_axis_tuser_i),
    .increment_i        (s_axis_tdata_i[0]),
    .verify_i           (s_axis_tdata_i[1]),
    .reply_wanted_i     (s_axis_tdata_i[2]),
    .reply_status_i     (s_axis_tdata_i[10:3]),
    .transaction_id_i   (s_axis_tdata_i[26:11]),
    .extended_address_i (s_axis_tdata_i[34:27]),
    .memory_address_i   (s_axis_tdata_i[66:35]),
    .data_length_i      (s_axis_tdata_i[90:67]),
    .data_byte_i        (s_axis_tdata_i[98:91]),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (m_axis_tready_i),
    .out_valid_o        (m_axis_tvalid_o),
    .out_byte_o         (m_axis_tdata_o),
    .end_of_packet_o    (m_axis_tlast_o),
    .last_o             (m_axis_tuser_o[0]),
    .error_o            (m_axis_tuser_o[1])
  );

endmodule
